// File: hw/rtl/stack_calculator_engine_defines.svh
// assertion macros for the stack calculator engine
`ifndef STACK_CALCULATOR_ENGINE_DEFINES_SVH
`define STACK_CALCULATOR_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCE_ASSERT(lbl, prop, msg)
`define SCE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/scm_pkg.sv
// constants and codes shared by the stack calculator engine
`timescale 1ns / 1ps
`default_nettype none
package scm_pkg;
  localparam int DATA_W = 32;
  localparam int DEFAULT_STACK_DEPTH = 16;

  localparam logic [7:0] CMD_PUSH  = 8'd1;
  localparam logic [7:0] CMD_PORT  = 8'd2;
  localparam logic [7:0] CMD_TOP   = 8'd4;
  localparam logic [7:0] CMD_DUMP  = 8'd5;
  localparam logic [7:0] CMD_SWAP  = 8'd7;
  localparam logic [7:0] CMD_NEG   = 8'd8;
  localparam logic [7:0] CMD_SUM   = 8'd10;
  localparam logic [7:0] CMD_ADD   = 8'd11;
  localparam logic [7:0] CMD_SUB   = 8'd12;
  localparam logic [7:0] CMD_MUL   = 8'd13;
  localparam logic [7:0] CMD_DIV   = 8'd14;
  localparam logic [7:0] CMD_CLEAR = 8'd254;
  localparam logic [7:0] CMD_HALT  = 8'd255;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_DIVZ  = 2'd3;
endpackage
`default_nettype wire

// File: hw/rtl/scm_ram.sv
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module scm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/stack_calculator_engine.sv
// stack calculator engine top level: sequencer around the stack ram
//
//  channel   handshake            fields
//  command   start && !busy       operation[7:0] operand[31:0]
//  result    strobe (one cycle)   port[7:0] value[31:0] error[1:0] last
//
// push, port, clear, halt and any early error finish in the accept cycle.
// top, negate: read the top entry; add, sub, swap, mul: also the next;
// div: a 32-step radix-2 divider; dump and sum: one entry per cycle, set by
// the single read port of the stack ram. busy is high while a command runs.
// synchronous reset empties the stack, selects port 0 and clears halt.
// results are registered after they are formed and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "stack_calculator_engine_defines.svh"
module stack_calculator_engine
  import scm_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [7:0]         operation,
  input  wire logic signed [31:0] operand,
  output logic                    strobe,
  output logic [7:0]              port,
  output logic signed [31:0]      value,
  output logic [1:0]              error,
  output logic                    last
);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TOP  = 3'd1;
  localparam logic [2:0] S_NXT  = 3'd2;
  localparam logic [2:0] S_SWP  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DFIN = 3'd6;
  localparam logic [2:0] S_WALK = 3'd7;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [7:0]        oport, oport_next;
  logic              halted, halted_next;
  logic [7:0]        op_r, op_r_next;
  logic [31:0]       t_r, t_r_next;
  logic [31:0]       n_r, n_r_next;
  logic [31:0]       acc, acc_next;
  logic [AW-1:0]     idx, idx_next;
  logic [31:0]       prod, prod_next;
  logic [31:0]       rem, rem_next;
  logic [31:0]       quo, quo_next;
  logic [31:0]       den, den_next;
  logic [4:0]        dcnt, dcnt_next;
  logic              qneg, qneg_next;

  logic              strobe_next;
  logic [31:0]       value_next;
  logic [1:0]        error_next;
  logic              last_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;

  logic [CW-1:0]     top_c, nxt_c;
  logic [AW-1:0]     top_a, nxt_a;
  logic [32:0]       trial;
  logic [31:0]       shifted;
  logic [31:0]       walk_sum;

  assign top_c = count - CW'(1);
  assign nxt_c = count - CW'(2);
  assign top_a = top_c[AW-1:0];
  assign nxt_a = nxt_c[AW-1:0];

  // one divider step: shift in next dividend bit, trial subtract
  assign shifted  = {rem[30:0], quo[31]};
  assign trial    = {rem[31], shifted} - {1'b0, den};
  assign walk_sum = acc + ram_rdata;

  scm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // command sequencer
  always_comb begin
    state_next  = state;
    count_next  = count;
    oport_next  = oport;
    halted_next = halted;
    op_r_next   = op_r;
    t_r_next    = t_r;
    n_r_next    = n_r;
    acc_next    = acc;
    idx_next    = idx;
    prod_next   = prod;
    rem_next    = rem;
    quo_next    = quo;
    den_next    = den;
    dcnt_next   = dcnt;
    qneg_next   = qneg;
    strobe_next = 1'b0;
    value_next  = 32'd0;
    error_next  = ERR_NONE;
    last_next   = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = top_a;
    ram_wdata   = 32'd0;
    ram_raddr   = top_a;

    case (state)
      S_IDLE: begin
        if (start && !halted) begin
          op_r_next = operation;
          case (operation)
            CMD_PUSH: begin
              if (count == CW'(STACK_DEPTH)) begin
                strobe_next = 1'b1;
                error_next  = ERR_OVER;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = count[AW-1:0];
                ram_wdata  = operand;
                count_next = count + CW'(1);
              end
            end
            CMD_PORT:  oport_next  = operand[7:0];
            CMD_CLEAR: count_next  = '0;
            CMD_HALT:  halted_next = 1'b1;
            CMD_TOP, CMD_NEG: begin
              if (count == '0) begin
                strobe_next = 1'b1;
                error_next  = ERR_UNDER;
              end else begin
                state_next = S_TOP;
              end
            end
            CMD_SWAP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (count < CW'(2)) begin
                strobe_next = 1'b1;
                error_next  = ERR_UNDER;
              end else begin
                state_next = S_TOP;
              end
            end
            CMD_DUMP, CMD_SUM: begin
              if (count != '0) begin
                acc_next   = 32'd0;
                idx_next   = top_a;
                state_next = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      // top entry is on the read data
      S_TOP: begin
        t_r_next = ram_rdata;
        if (op_r == CMD_TOP) begin
          strobe_next = 1'b1;
          value_next  = ram_rdata;
          state_next  = S_IDLE;
        end else if (op_r == CMD_NEG) begin
          ram_we     = 1'b1;
          ram_wdata  = 32'd0 - ram_rdata;
          state_next = S_IDLE;
        end else begin
          ram_raddr  = nxt_a;
          state_next = S_NXT;
        end
      end
      // next entry is on the read data
      S_NXT: begin
        n_r_next  = ram_rdata;
        ram_waddr = nxt_a;
        case (op_r)
          CMD_SWAP: begin
            ram_we     = 1'b1;
            ram_wdata  = t_r;
            state_next = S_SWP;
          end
          CMD_ADD, CMD_SUB: begin
            ram_we      = 1'b1;
            ram_wdata   = (op_r == CMD_ADD) ? ram_rdata + t_r : ram_rdata - t_r;
            value_next  = ram_wdata;
            strobe_next = 1'b1;
            count_next  = top_c;
            state_next  = S_IDLE;
          end
          CMD_MUL: begin
            prod_next  = ram_rdata * t_r;
            state_next = S_MUL;
          end
          default: begin
            if (t_r == 32'd0) begin
              strobe_next = 1'b1;
              error_next  = ERR_DIVZ;
              state_next  = S_IDLE;
            end else begin
              qneg_next  = ram_rdata[31] ^ t_r[31];
              quo_next   = ram_rdata[31] ? 32'd0 - ram_rdata : ram_rdata;
              den_next   = t_r[31] ? 32'd0 - t_r : t_r;
              rem_next   = 32'd0;
              dcnt_next  = 5'd0;
              state_next = S_DIV;
            end
          end
        endcase
      end
      S_SWP: begin
        ram_we     = 1'b1;
        ram_wdata  = n_r;
        state_next = S_IDLE;
      end
      S_MUL: begin
        ram_we      = 1'b1;
        ram_waddr   = nxt_a;
        ram_wdata   = prod;
        value_next  = prod;
        strobe_next = 1'b1;
        count_next  = top_c;
        state_next  = S_IDLE;
      end
      // restoring division, one quotient bit per cycle
      S_DIV: begin
        if (trial[32]) begin
          rem_next = shifted;
          quo_next = {quo[30:0], 1'b0};
        end else begin
          rem_next = trial[31:0];
          quo_next = {quo[30:0], 1'b1};
        end
        dcnt_next = dcnt + 5'd1;
        if (dcnt == 5'd31) begin
          state_next = S_DFIN;
        end
      end
      S_DFIN: begin
        ram_we      = 1'b1;
        ram_waddr   = nxt_a;
        ram_wdata   = qneg ? 32'd0 - quo : quo;
        value_next  = ram_wdata;
        strobe_next = 1'b1;
        count_next  = top_c;
        state_next  = S_IDLE;
      end
      // entry at idx is on the read data, walk toward the bottom
      S_WALK: begin
        acc_next    = walk_sum;
        strobe_next = 1'b1;
        value_next  = (op_r == CMD_SUM) ? walk_sum : ram_rdata;
        last_next   = (idx == '0);
        ram_raddr   = idx - AW'(1);
        idx_next    = idx - AW'(1);
        if (idx == '0) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      oport  <= 8'd0;
      halted <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      oport  <= oport_next;
      halted <= halted_next;
      strobe <= strobe_next;
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    op_r  <= op_r_next;
    t_r   <= t_r_next;
    n_r   <= n_r_next;
    acc   <= acc_next;
    idx   <= idx_next;
    prod  <= prod_next;
    rem   <= rem_next;
    quo   <= quo_next;
    den   <= den_next;
    dcnt  <= dcnt_next;
    qneg  <= qneg_next;
    port  <= oport;
    value <= value_next;
    error <= error_next;
    last  <= last_next;
  end

  assign busy = (state != S_IDLE);

  `SCE_ASSERT(a_err_last, strobe && (error != ERR_NONE) |-> last && (value == 32'd0), "error without last")
  `SCE_ASSERT(a_div_seq, (state == S_DIV) |=> (state == S_DIV) || (state == S_DFIN), "divider left early")
  `SCE_ASSERT(a_walk_end, (state == S_WALK) && (idx == '0) |=> (state == S_IDLE) && strobe && last, "walk end")
  `SCE_ASSERT(a_count_max, count <= CW'(STACK_DEPTH), "stack count beyond depth")
endmodule
`default_nettype wire

// File: sim/tb.sv
// self-checking testbench for the stack calculator engine
`timescale 1ns / 1ps
module tb;
  import scm_pkg::*;

  localparam int DEPTH = DEFAULT_STACK_DEPTH;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0]  op;
    logic [31:0] arg;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0]  port;
    logic [31:0] value;
    logic [1:0]  error;
    logic        last;
  } calc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [7:0] operation = '0;
  logic signed [31:0] operand = '0;
  wire busy, strobe, last;
  wire [7:0] port;
  wire signed [31:0] value;
  wire [1:0] error;

  stack_calculator_engine u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .operand(operand), .strobe(strobe),
    .port(port), .value(value), .error(error), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cmd_item_t pending_cmds[$];
  calc_result_t expected_results[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit stim_done = 1'b0;

  // predictor state
  logic [31:0] model_stack[DEPTH];
  int model_count = 0;
  logic [7:0] model_port = '0;
  bit model_halted = 1'b0;

  function automatic void push_expect(logic [31:0] v, logic [1:0] e, logic l);
    calc_result_t r;
    r.port = model_port;
    r.value = v;
    r.error = e;
    r.last = l;
    expected_results.push_back(r);
  endfunction

  function automatic logic [31:0] quotient(logic [31:0] n, logic [31:0] t);
    logic [31:0] na, ta, q;
    na = n[31] ? -n : n;
    ta = t[31] ? -t : t;
    q = na / ta;
    return (n[31] != t[31]) ? -q : q;
  endfunction

  // compute expected results of one accepted command
  function automatic void calc_predict(cmd_item_t c);
    logic [31:0] n, t, r, acc;
    if (model_halted) return;
    case (c.op)
      CMD_PUSH: begin
        if (model_count >= DEPTH) push_expect('0, ERR_OVER, 1'b1);
        else begin
          model_stack[model_count] = c.arg;
          model_count++;
        end
      end
      CMD_PORT: model_port = c.arg[7:0];
      CMD_TOP: begin
        if (model_count == 0) push_expect('0, ERR_UNDER, 1'b1);
        else push_expect(model_stack[model_count-1], ERR_NONE, 1'b1);
      end
      CMD_DUMP, CMD_SUM: begin
        acc = '0;
        for (int k = 0; k < model_count; k++) begin
          acc += model_stack[model_count-1-k];
          push_expect((c.op == CMD_SUM) ? acc : model_stack[model_count-1-k],
                      ERR_NONE, k + 1 == model_count);
        end
      end
      CMD_SWAP: begin
        if (model_count < 2) push_expect('0, ERR_UNDER, 1'b1);
        else begin
          t = model_stack[model_count-1];
          model_stack[model_count-1] = model_stack[model_count-2];
          model_stack[model_count-2] = t;
        end
      end
      CMD_NEG: begin
        if (model_count == 0) push_expect('0, ERR_UNDER, 1'b1);
        else model_stack[model_count-1] = -model_stack[model_count-1];
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (model_count < 2) push_expect('0, ERR_UNDER, 1'b1);
        else begin
          t = model_stack[model_count-1];
          n = model_stack[model_count-2];
          if (c.op == CMD_DIV && t == 0) push_expect('0, ERR_DIVZ, 1'b1);
          else begin
            case (c.op)
              CMD_ADD: r = n + t;
              CMD_SUB: r = n - t;
              CMD_MUL: r = n * t;
              default: r = quotient(n, t);
            endcase
            model_count--;
            model_stack[model_count-1] = r;
            push_expect(r, ERR_NONE, 1'b1);
          end
        end
      end
      CMD_CLEAR: model_count = 0;
      CMD_HALT: model_halted = 1'b1;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // driver: one item at a time with a random gap before each
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= $urandom_range(0, 7);
    end else if (start && !busy) begin
      calc_predict('{op: operation, arg: operand});
      start <= 1'b0;
      gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    end else if (!start) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (pending_cmds.size() > 0) begin
        cmd_item_t c;
        c = pending_cmds.pop_front();
        operation <= c.op;
        operand <= c.arg;
        start <= 1'b1;
      end
    end
  end

  // monitor: check each strobed result against the oldest expectation
  always @(posedge clk) begin
    calc_result_t w;
    cycle_count <= cycle_count + 1;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", value, 0);
      end else begin
        w = expected_results.pop_front();
        if (port !== w.port) report_mismatch("port", port, w.port);
        if (value !== w.value) report_mismatch("value", value, w.value);
        if (error !== w.error) report_mismatch("error", error, w.error);
        if (last !== w.last) report_mismatch("last", last, w.last);
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_cmd(logic [7:0] op, logic [31:0] arg);
    pending_cmds.push_back('{op: op, arg: arg});
  endfunction

  // stimulus: directed corner cases, then random sequences
  initial begin
    logic [7:0] arith_ops[4];
    logic [7:0] all_ops[12];
    int depth_track;
    arith_ops = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};
    all_ops = '{CMD_PUSH, CMD_PORT, CMD_TOP, CMD_DUMP, CMD_SWAP, CMD_NEG,
                CMD_SUM, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_CLEAR};
    // underflow on an empty stack, empty walks, unknown code
    add_cmd(CMD_TOP, 0);
    add_cmd(CMD_NEG, 0);
    add_cmd(CMD_DUMP, 0);
    add_cmd(CMD_SUM, 0);
    add_cmd(8'd3, 32'hffff_ffff);
    add_cmd(CMD_PUSH, 32'h8000_0000);
    add_cmd(CMD_SWAP, 0);
    add_cmd(CMD_ADD, 0);
    add_cmd(CMD_PUSH, 32'hffff_ffff);
    add_cmd(CMD_DIV, 0);            // most negative over minus one
    add_cmd(CMD_PUSH, 0);
    add_cmd(CMD_DIV, 0);            // division by zero
    add_cmd(CMD_PORT, 32'hffff_ffab);
    add_cmd(CMD_PUSH, 32'h7fff_ffff);
    add_cmd(CMD_MUL, 0);
    add_cmd(CMD_PUSH, -32'sd7);
    add_cmd(CMD_SUB, 0);
    // fill to overflow, then walk the full stack
    for (int i = 0; i < DEPTH; i++) add_cmd(CMD_PUSH, rand_word());
    add_cmd(CMD_DUMP, 0);
    add_cmd(CMD_SUM, 0);
    add_cmd(CMD_CLEAR, 0);
    add_cmd(CMD_PORT, 0);
    // random sequences, mostly legal with some errors and noise
    depth_track = 0;
    for (int i = 0; i < 230; i++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35 && depth_track < DEPTH) begin
        add_cmd(CMD_PUSH, rand_word());
        depth_track++;
      end else if (pick < 55 && depth_track >= 2) begin
        add_cmd(arith_ops[$urandom_range(0, 3)], $urandom);
        depth_track--;
      end else if (pick < 62) add_cmd(CMD_DUMP, $urandom);
      else if (pick < 69) add_cmd(CMD_SUM, $urandom);
      else if (pick < 74) add_cmd(CMD_TOP, $urandom);
      else if (pick < 78) add_cmd(CMD_SWAP, $urandom);
      else if (pick < 82) add_cmd(CMD_NEG, $urandom);
      else if (pick < 85) add_cmd(CMD_PORT, $urandom);
      else if (pick < 87) begin
        add_cmd(CMD_CLEAR, $urandom);
        depth_track = 0;
      end else if (pick < 90) add_cmd(8'($urandom_range(0, 255)), $urandom);
      else add_cmd(all_ops[$urandom_range(0, 11)], $urandom);
      // resync the estimate with the predictor cheaply: errors only shrink it
      if (depth_track > DEPTH) depth_track = DEPTH;
    end
    // halt, then everything is ignored
    add_cmd(CMD_HALT, $urandom);
    add_cmd(CMD_PUSH, 1);
    add_cmd(CMD_TOP, 0);
    add_cmd(CMD_DUMP, 0);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (pending_cmds.size() == 0 && !start && !busy);
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk);
    stim_done = 1'b1;
  end

  // end of run and timeout
  initial begin
    wait (stim_done || cycle_count >= CYCLE_LIMIT);
    if (!stim_done) begin
      $display("simulation failed");
    end else if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
